[design/bdq_pkg.sv]
package bdq_pkg;

    // fixed field widths of the command and response words
    localparam int FUNC_W = 3;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ       = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
    } t_rsp;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;   // open a gap at the target and store the new word
        logic rem;   // close the gap at the target
        logic tap;   // the target cell drives its word into the read tree
    } t_cell_ctl;

    // levels of a 4-ary reduction tree over n leaves (at least one)
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = 4;
        while (span < n) begin
            lv   = lv + 1;
            span = span * 4;
        end
        return lv;
    endfunction

endpackage

[design/bdq_cell.sv]
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 11,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CW-1:0]         i_target,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_val,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  w_hit;
    logic                  w_above;

    assign w_hit   = (i_target == CW'(IDX));
    assign w_above = (CW'(IDX) > i_target);

    // shift toward the back on insert, toward the front on removal
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_hit) begin
            r_data <= i_val;
        end else if (i_ctl.ins && w_above) begin
            r_data <= i_left;
        end else if (i_ctl.rem && (w_hit || w_above)) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;
    // pre-shift word of the selected cell, zero elsewhere
    assign o_tap  = (i_ctl.tap && w_hit) ? r_data : '0;

endmodule

[design/bdq_or_tree.sv]
module bdq_or_tree
    import bdq_pkg::*;
#(
    parameter int N = 1024,
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    // 4-ary heap: children of node g sit at 4g+1 .. 4g+4
    localparam int LV    = tree_levels(N);
    localparam int SPAN  = 4 ** LV;
    localparam int OFF_L = (SPAN - 1) / 3;
    localparam int TOT   = OFF_L + SPAN;

    logic [W-1:0] r_node [TOT];

    for (genvar g = 0; g < TOT; g++) begin : g_node
        if (g < OFF_L) begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[g] <= r_node[4*g+1] | r_node[4*g+2]
                           | r_node[4*g+3] | r_node[4*g+4];
            end
        end else if (g - OFF_L < N) begin : g_leaf
            always_ff @(posedge i_clk) begin
                r_node[g] <= i_leaf[g-OFF_L];
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[g] <= '0;
            end
        end
    end

    assign o_root = r_node[0];

endmodule

[design/bounded_deque_with_indexed_insert_top.sv]
// Result path: the tapped word is registered at the tree leaves and at every level of the 4-ary
//   tree; the strobe, status and count follow in shift registers of matching length.
//   The delay is set by the registered 4-ary tree that gathers the read word.
// Throughput: one word per cycle; busy stays low, the cell row shifts in the accepting cycle.
// Reset: synchronous; the element count and the strobe pipeline clear, while the status and
//   count pipeline and cell contents are not cleared. Results cannot be stalled by the receiver.
module bounded_deque_with_indexed_insert_top
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_strobe,
    output t_rsp o_result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int LAT  = tree_levels(DEPTH) + 1;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
    } t_meta;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [LAT-1:0]        r_vpipe;
    t_meta                 r_mpipe [LAT];
    logic                  w_acc;
    logic [CMPW-1:0]       w_posx;
    logic [CMPW-1:0]       w_cntx;
    logic                  w_full;
    logic                  w_empty;
    logic [ST_W-1:0]       w_status;
    logic [CW-1:0]         w_target;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];
    logic [DATA_WIDTH-1:0] w_root;
    logic [VAL_W-1:0]      w_rv;

    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    // value width adaption
    if (DATA_WIDTH > VAL_W) begin : g_val_ext
        assign w_val = {{(DATA_WIDTH-VAL_W){1'b0}}, i_cmd.value};
    end else begin : g_val_cut
        assign w_val = i_cmd.value[DATA_WIDTH-1:0];
    end

    if (DATA_WIDTH < VAL_W) begin : g_rv_ext
        assign w_rv = {{(VAL_W-DATA_WIDTH){1'b0}}, w_root};
    end else begin : g_rv_cut
        assign w_rv = w_root[VAL_W-1:0];
    end

    assign w_posx  = CMPW'(i_cmd.position);
    assign w_cntx  = CMPW'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // operation decode: status, target cell and shift direction
    always_comb begin
        w_status = ST_OK;
        w_target = '0;
        w_ctl    = '0;
        n_count  = r_count;
        unique case (i_cmd.func)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_target  = (i_cmd.func == FN_PUSH_BACK) ? r_count : '0;
                    n_count   = r_count + CW'(1);
                end
            end
            FN_POP_BACK, FN_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl.rem = 1'b1;
                    w_ctl.tap = 1'b1;
                    w_target  = (i_cmd.func == FN_POP_BACK) ? r_count - CW'(1) : '0;
                    n_count   = r_count - CW'(1);
                end
            end
            FN_INSERT: begin
                if (w_posx > w_cntx) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_target  = CW'(i_cmd.position);
                    n_count   = r_count + CW'(1);
                end
            end
            FN_ERASE, FN_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_posx >= w_cntx) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.tap = 1'b1;
                    w_target  = CW'(i_cmd.position);
                    if (i_cmd.func == FN_ERASE) begin
                        w_ctl.rem = 1'b1;
                        n_count   = r_count - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        if (!w_acc) begin
            w_ctl   = '0;
            n_count = r_count;
        end
    end

    // row of element cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        bdq_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_target(w_target),
            .i_left  (w_left),
            .i_right (w_right),
            .i_val   (w_val),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // read word gathering
    bdq_or_tree #(
        .N(DEPTH),
        .W(DATA_WIDTH)
    ) u_tree (
        .i_clk (i_clk),
        .i_leaf(w_tap),
        .o_root(w_root)
    );

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result pipeline, aligned with the tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mpipe[0] <= '{status: w_status, count: CNT_W'(n_count)};
        for (int k = 1; k < LAT; k++) begin
            r_mpipe[k] <= r_mpipe[k-1];
        end
    end

    assign o_strobe            = r_vpipe[LAT-1];
    assign o_result.read_value = w_rv;
    assign o_result.status     = r_mpipe[LAT-1].status;
    assign o_result.count      = r_mpipe[LAT-1].count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##(LAT) o_strobe)
        else $error("result strobe missing after accepted word");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> (o_result.read_value == '0))
        else $error("failed operation returned data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status == ST_FULL) |=> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

endmodule

[tb/bounded_deque_with_indexed_insert_top_tb.sv]
`timescale 1ns / 100ps

module bounded_deque_with_indexed_insert_top_tb
    import bdq_pkg::*;
();

    localparam int DEPTH      = 1024;
    localparam int LATENCY    = 6;
    localparam int IDLE_LIMIT = 1000;
    localparam int QUEUE_ROOM = 4;

    // code 7 is not decoded by the block
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_cmd i_cmd   = '0;
    logic o_busy;
    logic o_strobe;
    t_rsp o_result;

    // shadow copy of the deque contents
    logic signed [VAL_W-1:0] shadow_cells [DEPTH];
    int                      shadow_fill = 0;

    t_cmd cmd_pending  [$];
    t_rsp rsp_expected [$];

    logic word_taken  = 1'b0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    int   idle_cycles = 0;
    int   err_count   = 0;

    bounded_deque_with_indexed_insert_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VAL_W)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one command to the shadow deque and return the response it should give
    function automatic t_rsp deque_response(t_cmd c);
        t_rsp r;
        int   pos;
        int   idx;
        int   k;
        logic do_ins;
        logic do_rem;
        r      = '0;
        r.status = ST_OK;
        pos    = int'(c.position);
        idx    = 0;
        do_ins = 1'b0;
        do_rem = 1'b0;
        case (c.func)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = (c.func == FN_PUSH_BACK) ? shadow_fill : 0;
                end
            end
            FN_POP_BACK, FN_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                    idx    = (c.func == FN_POP_BACK) ? shadow_fill - 1 : 0;
                end
            end
            FN_INSERT: begin
                // range check wins over the full check
                if (pos > shadow_fill) begin
                    r.status = ST_RANGE;
                end else if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = pos;
                end
            end
            FN_ERASE, FN_READ: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= shadow_fill) begin
                    r.status = ST_RANGE;
                end else if (c.func == FN_ERASE) begin
                    do_rem = 1'b1;
                    idx    = pos;
                end else begin
                    r.read_value = shadow_cells[pos];
                end
            end
            default: begin
            end
        endcase
        // open a gap and store the new word
        if (do_ins) begin
            for (k = shadow_fill; k > idx; k--) begin
                shadow_cells[k] = shadow_cells[k-1];
            end
            shadow_cells[idx] = c.value;
            shadow_fill++;
        end
        // take the word out and close the gap
        if (do_rem) begin
            r.read_value = shadow_cells[idx];
            for (k = idx; k < shadow_fill - 1; k++) begin
                shadow_cells[k] = shadow_cells[k+1];
            end
            shadow_fill--;
        end
        r.count = CNT_W'(shadow_fill);
        return r;
    endfunction

    // random command; grow_pct sets the share of pushes and inserts
    function automatic t_cmd random_cmd(int grow_pct);
        t_cmd c;
        int   sel;
        c.value = $urandom();
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            c.value = 32'sh8000_0000;
        end else if (sel == 1) begin
            c.value = 32'sh7fff_ffff;
        end else if (sel == 2) begin
            c.value = '0;
        end else if (sel == 3) begin
            c.value = -32'sd1;
        end
        if ($urandom_range(0, 99) < grow_pct) begin
            case ($urandom_range(0, 2))
                0:       c.func = FN_PUSH_BACK;
                1:       c.func = FN_PUSH_FRONT;
                default: c.func = FN_INSERT;
            endcase
        end else begin
            case ($urandom_range(0, 8))
                0:       c.func = FN_POP_BACK;
                1:       c.func = FN_POP_FRONT;
                2, 3:    c.func = FN_ERASE;
                7:       c.func = FN_UNUSED;
                default: c.func = FN_READ;
            endcase
        end
        // positions mostly inside the list, with edges and wild values mixed in
        case ($urandom_range(0, 9))
            0:       c.position = '0;
            1:       c.position = POS_W'(shadow_fill);
            2:       c.position = POS_W'(shadow_fill > 0 ? shadow_fill - 1 : 0);
            3:       c.position = POS_W'($urandom_range(0, 2047));
            default: c.position = POS_W'($urandom_range(0, shadow_fill));
        endcase
        return c;
    endfunction

    // hand a word to the driver once there is room in the pending queue
    task automatic queue_word(t_cmd c);
        while (cmd_pending.size() >= QUEUE_ROOM) begin
            @(posedge i_clk);
            #1;
        end
        cmd_pending = {cmd_pending, c};
    endtask

    // driver: new word or idle at the falling edge, in bursts with gaps
    always @(negedge i_clk) begin
        logic start_nxt;
        t_cmd cmd_nxt;
        start_nxt = i_start;
        cmd_nxt   = i_cmd;
        if (!i_rst_n) begin
            start_nxt = 1'b0;
        end else if (!i_start || word_taken) begin
            start_nxt        = 1'b0;
            cmd_nxt.func     = FUNC_W'($urandom_range(0, 7));
            cmd_nxt.position = POS_W'($urandom_range(0, 2047));
            cmd_nxt.value    = $urandom();
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_pending.size() > 0) begin
                cmd_nxt   = cmd_pending.pop_front();
                start_nxt = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        i_start <= start_nxt;
        i_cmd   <= cmd_nxt;
    end

    // monitor: predict on accept, check each strobed response, watch for stalls
    always @(posedge i_clk) begin
        t_rsp want;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                rsp_expected = {rsp_expected, deque_response(i_cmd)};
                word_taken = 1'b1;
            end
            if (o_strobe) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: unexpected response, actual %p", $time, o_result);
                    err_count++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (o_result.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, o_result.read_value);
                        err_count++;
                    end
                    if (o_result.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_result.status);
                        err_count++;
                    end
                    if (o_result.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, o_result.count);
                        err_count++;
                    end
                end
            end
            if (word_taken || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, slips around insert, extremes, unused code
        queue_word('{FN_READ,       11'd0,    32'sd0});
        queue_word('{FN_ERASE,      11'd0,    32'sd0});
        queue_word('{FN_POP_BACK,   11'd0,    32'sd0});
        queue_word('{FN_POP_FRONT,  11'd0,    32'sd0});
        queue_word('{FN_INSERT,     11'd1,    32'sd5});
        queue_word('{FN_INSERT,     11'd0,    32'sd11});
        queue_word('{FN_PUSH_BACK,  11'd2047, 32'sh7fff_ffff});
        queue_word('{FN_PUSH_FRONT, 11'd0,    32'sh8000_0000});
        queue_word('{FN_INSERT,     11'd2,    -32'sd7});
        queue_word('{FN_INSERT,     11'd4,    32'sd99});
        queue_word('{FN_INSERT,     11'd5,    32'sd42});
        queue_word('{FN_INSERT,     11'd0,    -32'sd1});
        queue_word('{FN_READ,       11'd0,    32'sd0});
        queue_word('{FN_READ,       11'd5,    32'sd0});
        queue_word('{FN_READ,       11'd6,    32'sd0});
        queue_word('{FN_READ,       11'd2047, 32'sd0});
        queue_word('{FN_ERASE,      11'd1,    32'sd0});
        queue_word('{FN_ERASE,      11'd5,    32'sd0});
        queue_word('{FN_UNUSED,     11'd3,    32'sd123});
        queue_word('{FN_POP_BACK,   11'd0,    32'sd0});
        queue_word('{FN_POP_FRONT,  11'd0,    32'sd0});
        queue_word('{FN_PUSH_BACK,  11'd1024, 32'sd0});
        queue_word('{FN_READ,       11'd1024, 32'sd0});

        // grow toward full with random content, then work around the full mark
        n = 0;
        while (shadow_fill < DEPTH && n < 3000) begin
            queue_word(random_cmd(97));
            n++;
        end
        repeat (30) queue_word(random_cmd(50));
        repeat (20) queue_word(random_cmd(20));

        // let every word go out and every response come back
        while (cmd_pending.size() != 0 || i_start) begin
            @(posedge i_clk);
            #1;
        end
        while (rsp_expected.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        #1;
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/bdq_pkg.sv
design/bdq_cell.sv
design/bdq_or_tree.sv
design/bounded_deque_with_indexed_insert_top.sv
tb/bounded_deque_with_indexed_insert_top_tb.sv
